FILE: design/bbr_pkg.sv
// Shared types and constants for the bad block remap / CHS translation block.
// Used by the divider, the top level and the testbench.
// No dependencies.
package bbr_pkg;

    // Table depths
    localparam int TRACK_TABLE_DEPTH  = 64;
    localparam int SECTOR_TABLE_DEPTH = 64;

    localparam int TT_AW = (TRACK_TABLE_DEPTH > 1) ? $clog2(TRACK_TABLE_DEPTH) : 1;
    localparam int ST_AW = (SECTOR_TABLE_DEPTH > 1) ? $clog2(SECTOR_TABLE_DEPTH) : 1;
    localparam int TT_NW = $clog2(TRACK_TABLE_DEPTH + 1);
    localparam int ST_NW = $clog2(SECTOR_TABLE_DEPTH + 1);
    localparam int SCAN_W = (TT_NW > ST_NW) ? TT_NW : ST_NW;
    localparam int OFF_W  = SCAN_W + 6;

    // Divider widths: 32-bit dividend, divisor up to 63 * 256
    localparam int DIVD_W = 32;
    localparam int DIVS_W = 14;
    localparam int DIV_CW = $clog2(DIVD_W);

    localparam logic [5:0] SPT_RESET   = 6'd63;
    localparam logic [8:0] HEADS_RESET = 9'd16;
    localparam logic [8:0] HEADS_MAX   = 9'd256;

    typedef logic [TT_AW-1:0]  tt_addr_t;
    typedef logic [ST_AW-1:0]  st_addr_t;
    typedef logic [SCAN_W-1:0] scan_t;
    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [DIVS_W-1:0] divs_t;
    typedef logic [DIV_CW-1:0] div_cnt_t;

    typedef enum logic [1:0] {
        OP_TRANSLATE   = 2'd0,
        OP_LOAD_TRACK  = 2'd1,
        OP_LOAD_SECTOR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_TRACK  = 2'd1,
        KIND_SECTOR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_SPT          = 3'd0,
        REG_HEADS        = 3'd1,
        REG_ENABLE       = 3'd2,
        REG_TRACK_BASE   = 3'd3,
        REG_SECTOR_BASE  = 3'd4,
        REG_TRACK_COUNT  = 3'd5,
        REG_SECTOR_COUNT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        divs_t             divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quot;
        divs_t             rem;
    } div_rsp_t;

endpackage

FILE: design/bbr_if.sv
// Channel interfaces for the bad block remap block: input words, result words,
// and configuration writes. Depends on nothing; widths follow the field list.
interface bbr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [5:0]  entry_index;
    logic [31:0] entry_value;
    logic [31:0] logical_sector;

    modport source (output valid, output op, output entry_index, output entry_value,
                    output logical_sector, input ready);
    modport sink (input valid, input op, input entry_index, input entry_value,
                  input logical_sector, output ready);
endinterface

interface bbr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mapped_sector;
    logic [31:0] cylinder;
    logic [7:0]  head;
    logic [5:0]  sector_in_track;
    logic [1:0]  remap_kind;

    modport source (output valid, output mapped_sector, output cylinder, output head,
                    output sector_in_track, output remap_kind, input ready);
    modport sink (input valid, input mapped_sector, input cylinder, input head,
                  input sector_in_track, input remap_kind, output ready);
endinterface

interface bbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/bbr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/bbr_div.sv
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 14-bit divisor.
// Depends on bbr_pkg for widths and the request / response structs.
module bbr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bbr_pkg::div_req_t req,
    output bbr_pkg::div_rsp_t rsp
);

    logic                             busy_reg;
    logic                             done_reg;
    bbr_pkg::div_cnt_t                cnt_reg;
    logic [bbr_pkg::DIVD_W-1:0]       quot_reg;
    bbr_pkg::divs_t                   rem_reg;
    bbr_pkg::divs_t                   dsr_reg;

    logic [bbr_pkg::DIVS_W:0]         trial;
    logic                             fits;
    bbr_pkg::divs_t                   rem_next;

    // Shift in the next dividend bit, subtract when the divisor fits
    always_comb
    begin
        trial = {rem_reg, quot_reg[bbr_pkg::DIVD_W-1]};
        fits  = (trial >= {1'b0, dsr_reg});
        if (fits)
        begin
            rem_next = bbr_pkg::divs_t'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = trial[bbr_pkg::DIVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= bbr_pkg::div_cnt_t'(bbr_pkg::DIVD_W - 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            quot_reg <= {quot_reg[bbr_pkg::DIVD_W-2:0], fits};
            rem_reg  <= rem_next;
        end
        else if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            dsr_reg  <= req.divisor;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: design/bad_block_remap_chs_top.sv
// Bad block remap and CHS split. A translate word holds the input while it makes up to
// three passes through the shared radix-2 divider (two with remapping off) plus one
// table read per scanned used bad-track / bad-sector entry, and while the receiver
// holds the result register. One word is in work at a time. Reset restores register
// defaults and control state, not table contents.
module bad_block_remap_chs_top (
    input  logic   clk,
    input  logic   rst_n,
    bbr_in_if.sink    item,
    bbr_out_if.source result,
    bbr_cfg_if.sink   cfg
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TDIV,
        S_TWAIT,
        S_TSCAN,
        S_SSCAN,
        S_FIX,
        S_ADD,
        S_CDIV,
        S_CWAIT,
        S_HDIV,
        S_HWAIT,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [5:0]  spt_reg;
    logic [8:0]  heads_reg;
    logic        en_reg;
    logic [31:0] tbase_reg;
    logic [31:0] sbase_reg;
    logic [6:0]  tcnt_reg;
    logic [6:0]  scnt_reg;

    // ------------------------------------------------------------------
    // Control and work registers
    // ------------------------------------------------------------------
    state_t              state_reg,    state_next;
    logic                pend_reg,     pend_next;
    logic                out_valid_reg, out_valid_next;

    logic [31:0]         sec_reg,      sec_next;
    logic [5:0]          wspt_reg,     wspt_next;
    bbr_pkg::divs_t      spc_reg,      spc_next;
    logic [31:0]         key_reg,      key_next;
    logic [5:0]          remt_reg,     remt_next;
    bbr_pkg::scan_t      scan_idx_reg, scan_idx_next;
    bbr_pkg::scan_t      n_reg,        n_next;
    bbr_pkg::scan_t      pend_idx_reg, pend_idx_next;
    bbr_pkg::scan_t      hit_idx_reg,  hit_idx_next;
    bbr_pkg::kind_t      kind_reg,     kind_next;
    bbr_pkg::off_t       off_reg,      off_next;
    logic [31:0]         mapped_reg,   mapped_next;
    logic [31:0]         cyl_reg,      cyl_next;
    bbr_pkg::divs_t      within_reg,   within_next;
    logic [7:0]          head_reg,     head_next;
    logic [5:0]          sit_reg,      sit_next;

    // Output word register
    logic [31:0]         out_mapped_reg;
    logic [31:0]         out_cyl_reg;
    logic [7:0]          out_head_reg;
    logic [5:0]          out_sit_reg;
    bbr_pkg::kind_t      out_kind_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                item_acc;
    logic                out_load;
    logic [5:0]          wspt_c;
    logic [8:0]          heads_c;
    bbr_pkg::divs_t      spc_c;
    bbr_pkg::scan_t      tn_c;
    bbr_pkg::scan_t      sn_c;
    logic [31:0]         rd_word;
    logic                hit;
    logic                scan_end;

    // Table memories
    logic                tt_wr_en,  st_wr_en;
    logic                tt_rd_en,  st_rd_en;
    logic [31:0]         tt_rd_data, st_rd_data;

    // Shared divider
    bbr_pkg::div_req_t   div_req;
    bbr_pkg::div_rsp_t   div_rsp;

    assign item.ready = (state_reg == S_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Loads are taken only in idle, so a table write never overlaps a scan read
    assign tt_wr_en = item_acc && (item.op == bbr_pkg::OP_LOAD_TRACK)
                      && (32'(item.entry_index) < 32'(bbr_pkg::TRACK_TABLE_DEPTH));
    assign st_wr_en = item_acc && (item.op == bbr_pkg::OP_LOAD_SECTOR)
                      && (32'(item.entry_index) < 32'(bbr_pkg::SECTOR_TABLE_DEPTH));

    bbr_ram #(
        .WIDTH (32),
        .DEPTH (bbr_pkg::TRACK_TABLE_DEPTH)
    ) u_track_ram (
        .clk     (clk),
        .wr_en   (tt_wr_en),
        .wr_addr (bbr_pkg::tt_addr_t'(item.entry_index)),
        .wr_data (item.entry_value),
        .rd_en   (tt_rd_en),
        .rd_addr (scan_idx_reg[bbr_pkg::TT_AW-1:0]),
        .rd_data (tt_rd_data)
    );

    bbr_ram #(
        .WIDTH (32),
        .DEPTH (bbr_pkg::SECTOR_TABLE_DEPTH)
    ) u_sector_ram (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (bbr_pkg::st_addr_t'(item.entry_index)),
        .wr_data (item.entry_value),
        .rd_en   (st_rd_en),
        .rd_addr (scan_idx_reg[bbr_pkg::ST_AW-1:0]),
        .rd_data (st_rd_data)
    );

    bbr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Clamp geometry and counts to legal ranges
    always_comb
    begin
        wspt_c  = (spt_reg == 6'd0) ? 6'd1 : spt_reg;
        if (heads_reg == 9'd0)
        begin
            heads_c = 9'd1;
        end
        else if (heads_reg > bbr_pkg::HEADS_MAX)
        begin
            heads_c = bbr_pkg::HEADS_MAX;
        end
        else
        begin
            heads_c = heads_reg;
        end
        spc_c = bbr_pkg::divs_t'(wspt_c) * bbr_pkg::divs_t'(heads_c);

        if (32'(tcnt_reg) > 32'(bbr_pkg::TRACK_TABLE_DEPTH))
        begin
            tn_c = bbr_pkg::scan_t'(bbr_pkg::TRACK_TABLE_DEPTH);
        end
        else
        begin
            tn_c = bbr_pkg::scan_t'(tcnt_reg);
        end
        if (32'(scnt_reg) > 32'(bbr_pkg::SECTOR_TABLE_DEPTH))
        begin
            sn_c = bbr_pkg::scan_t'(bbr_pkg::SECTOR_TABLE_DEPTH);
        end
        else
        begin
            sn_c = bbr_pkg::scan_t'(scnt_reg);
        end
    end

    // Divider operand select
    always_comb
    begin
        div_req.start = (state_reg == S_TDIV) || (state_reg == S_CDIV)
                        || (state_reg == S_HDIV);
        case (state_reg)
            S_TDIV:
            begin
                div_req.dividend = sec_reg;
                div_req.divisor  = bbr_pkg::divs_t'(wspt_reg);
            end
            S_CDIV:
            begin
                div_req.dividend = mapped_reg;
                div_req.divisor  = spc_reg;
            end
            default:
            begin
                div_req.dividend = 32'(within_reg);
                div_req.divisor  = bbr_pkg::divs_t'(wspt_reg);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: the scan issues one table read per cycle and compares the
    // word read in the cycle before, so a pending read trails the address.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        sec_next      = sec_reg;
        wspt_next     = wspt_reg;
        spc_next      = spc_reg;
        key_next      = key_reg;
        remt_next     = remt_reg;
        scan_idx_next = scan_idx_reg;
        n_next        = n_reg;
        pend_idx_next = pend_idx_reg;
        hit_idx_next  = hit_idx_reg;
        kind_next     = kind_reg;
        off_next      = off_reg;
        mapped_next   = mapped_reg;
        cyl_next      = cyl_reg;
        within_next   = within_reg;
        head_next     = head_reg;
        sit_next      = sit_reg;
        tt_rd_en      = 1'b0;
        st_rd_en      = 1'b0;
        out_load      = 1'b0;

        rd_word  = (state_reg == S_TSCAN) ? tt_rd_data : st_rd_data;
        hit      = pend_reg && (rd_word == key_reg);
        scan_end = (scan_idx_reg == n_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc && (item.op == bbr_pkg::OP_TRANSLATE))
                begin
                    sec_next    = item.logical_sector;
                    mapped_next = item.logical_sector;
                    kind_next   = bbr_pkg::KIND_NONE;
                    wspt_next   = wspt_c;
                    spc_next    = spc_c;
                    state_next  = en_reg ? S_TDIV : S_CDIV;
                end
            end
            S_TDIV:
            begin
                state_next = S_TWAIT;
            end
            S_TWAIT:
            begin
                if (div_rsp.done)
                begin
                    key_next      = div_rsp.quot;
                    remt_next     = div_rsp.rem[5:0];
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    n_next        = tn_c;
                    state_next    = S_TSCAN;
                end
            end
            S_TSCAN, S_SSCAN:
            begin
                if (hit)
                begin
                    hit_idx_next = pend_idx_reg;
                    kind_next    = (state_reg == S_TSCAN) ? bbr_pkg::KIND_TRACK
                                                          : bbr_pkg::KIND_SECTOR;
                    pend_next    = 1'b0;
                    state_next   = S_FIX;
                end
                else if (scan_end)
                begin
                    pend_next = 1'b0;
                    if (state_reg == S_TSCAN)
                    begin
                        // Track miss: move on to the bad sector table
                        key_next      = sec_reg;
                        scan_idx_next = '0;
                        n_next        = sn_c;
                        state_next    = S_SSCAN;
                    end
                    else
                    begin
                        state_next = S_CDIV;
                    end
                end
                else
                begin
                    tt_rd_en      = (state_reg == S_TSCAN);
                    st_rd_en      = (state_reg == S_SSCAN);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = bbr_pkg::scan_t'(scan_idx_reg + 1'b1);
                end
            end
            S_FIX:
            begin
                if (kind_reg == bbr_pkg::KIND_TRACK)
                begin
                    off_next = bbr_pkg::off_t'(hit_idx_reg) * bbr_pkg::off_t'(wspt_reg)
                               + bbr_pkg::off_t'(remt_reg);
                end
                else
                begin
                    off_next = bbr_pkg::off_t'(hit_idx_reg);
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (kind_reg == bbr_pkg::KIND_TRACK)
                begin
                    mapped_next = tbase_reg + 32'(off_reg);
                end
                else
                begin
                    mapped_next = sbase_reg + 32'(off_reg);
                end
                state_next = S_CDIV;
            end
            S_CDIV:
            begin
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (div_rsp.done)
                begin
                    cyl_next    = div_rsp.quot;
                    within_next = div_rsp.rem;
                    state_next  = S_HDIV;
                end
            end
            S_HDIV:
            begin
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (div_rsp.done)
                begin
                    // spc is a multiple of spt, so within % spt == mapped % spt
                    head_next  = div_rsp.quot[7:0];
                    sit_next   = div_rsp.rem[5:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free or being emptied
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State, configuration and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            spt_reg       <= bbr_pkg::SPT_RESET;
            heads_reg     <= bbr_pkg::HEADS_RESET;
            en_reg        <= 1'b0;
            tbase_reg     <= '0;
            sbase_reg     <= '0;
            tcnt_reg      <= '0;
            scnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (bbr_pkg::cfg_reg_t'(cfg.index))
                    bbr_pkg::REG_SPT:          spt_reg   <= cfg.data[5:0];
                    bbr_pkg::REG_HEADS:        heads_reg <= cfg.data[8:0];
                    bbr_pkg::REG_ENABLE:       en_reg    <= cfg.data[0];
                    bbr_pkg::REG_TRACK_BASE:   tbase_reg <= cfg.data;
                    bbr_pkg::REG_SECTOR_BASE:  sbase_reg <= cfg.data;
                    bbr_pkg::REG_TRACK_COUNT:  tcnt_reg  <= cfg.data[6:0];
                    bbr_pkg::REG_SECTOR_COUNT: scnt_reg  <= cfg.data[6:0];
                    default:
                    begin
                        // drop writes past the register list
                    end
                endcase
            end
        end
    end

    // Work and output payload
    always_ff @(posedge clk)
    begin
        sec_reg      <= sec_next;
        wspt_reg     <= wspt_next;
        spc_reg      <= spc_next;
        key_reg      <= key_next;
        remt_reg     <= remt_next;
        scan_idx_reg <= scan_idx_next;
        n_reg        <= n_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        kind_reg     <= kind_next;
        off_reg      <= off_next;
        mapped_reg   <= mapped_next;
        cyl_reg      <= cyl_next;
        within_reg   <= within_next;
        head_reg     <= head_next;
        sit_reg      <= sit_next;
        if (out_load)
        begin
            out_mapped_reg <= mapped_reg;
            out_cyl_reg    <= cyl_reg;
            out_head_reg   <= head_reg;
            out_sit_reg    <= sit_reg;
            out_kind_reg   <= kind_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.mapped_sector   = out_mapped_reg;
    assign result.cylinder        = out_cyl_reg;
    assign result.head            = out_head_reg;
    assign result.sector_in_track = out_sit_reg;
    assign result.remap_kind      = out_kind_reg;

`ifndef SYNTHESIS
    // The scan address never runs past the used entry count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TSCAN || state_reg == S_SSCAN) |-> (scan_idx_reg <= n_reg))
        else $error("scan index beyond used entries");

    // The divider is started only when it is free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A hit always names a used table entry
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX) |-> (hit_idx_reg < n_reg))
        else $error("hit index outside used entries");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for bad_block_remap_chs_top: bad-track / bad-sector remap and CHS split.
// Drives load and translate words, writes the setup registers between phases, predicts results.
// Depends on bbr_pkg, the bbr_*_if interfaces and the design top.
module tb_top;
    import bbr_pkg::*;

    // op code 3 has no meaning; the block must swallow it without a result
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES  = 400;
    localparam int SQUEEZE_CYCLES = 1500;     // one long receiver hold-off
    localparam int LIMIT_CYCLES   = 3000000;
    localparam int RANDOM_WORDS   = 1300;

    // One translate result, field for field as the result channel carries it
    typedef struct packed {
        logic [31:0] mapped;
        logic [31:0] cyl;
        logic [7:0]  head;
        logic [5:0]  sit;
        kind_t       kind;
    } chs_t;

    // One row of the directed table: either a register write or an input word
    typedef struct {
        logic        is_cfg;
        cfg_reg_t    sel;
        logic [31:0] data;
        logic [1:0]  op;
        logic [5:0]  idx;
        logic [31:0] val;
        logic [31:0] lsec;
        logic        typed;
        chs_t        want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    bbr_in_if  item_if ();
    bbr_out_if res_if ();
    bbr_cfg_if cfg_if ();

    bad_block_remap_chs_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // Shadow copy of the setup registers and both bad-block tables
    logic [5:0]  spt_reg;
    logic [8:0]  heads_reg;
    logic        remap_on;
    logic [31:0] trk_base;
    logic [31:0] sec_base;
    logic [6:0]  trk_used;
    logic [6:0]  sec_used;
    logic [31:0] trk_tab [TRACK_TABLE_DEPTH];
    logic [31:0] sec_tab [SECTOR_TABLE_DEPTH];

    chs_t      chs_pending[$];       // results owed by the block, oldest first
    plan_row_t plan[$];
    int        chs_mismatches = 0;
    int        burst_left = 0;
    logic      cfg_open = 1'b0;      // config valid still raised from the last write
    logic      words_since_idle = 1'b0;
    logic      squeeze_go = 1'b0;

    // Work out the translate result from the shadow state.
    // Lowest matching bad-track entry wins; only then are bad sectors searched.
    function automatic chs_t chs_translate(input logic [31:0] lsec);
        chs_t        r;
        logic [31:0] spt;
        logic [31:0] heads;
        logic [31:0] spc;
        logic [31:0] trk;
        int          n;
        int          i;
        spt   = (spt_reg == 6'd0) ? 32'd1 : {26'd0, spt_reg};
        heads = (heads_reg == 9'd0) ? 32'd1 :
                (heads_reg > 9'd256) ? 32'd256 : {23'd0, heads_reg};
        spc = spt * heads;
        r.mapped = lsec;
        r.kind   = KIND_NONE;
        if (remap_on)
        begin
            trk = lsec / spt;
            // counts above the table depth are clamped to the depth
            n = (trk_used > TRACK_TABLE_DEPTH) ? TRACK_TABLE_DEPTH : int'(trk_used);
            for (i = 0; i < n; i++)
            begin
                if (r.kind == KIND_NONE && trk_tab[i] == trk)
                begin
                    r.mapped = trk_base + i * spt + lsec % spt;
                    r.kind   = KIND_TRACK;
                end
            end
            n = (sec_used > SECTOR_TABLE_DEPTH) ? SECTOR_TABLE_DEPTH : int'(sec_used);
            for (i = 0; i < n; i++)
            begin
                if (r.kind == KIND_NONE && sec_tab[i] == lsec)
                begin
                    r.mapped = sec_base + i;
                    r.kind   = KIND_SECTOR;
                end
            end
        end
        r.cyl  = r.mapped / spc;
        r.head = 8'((r.mapped % spc) / spt);
        r.sit  = 6'(r.mapped % spt);
        return r;
    endfunction

    function automatic chs_t chs(input logic [31:0] m, input logic [31:0] c,
                                 input logic [7:0] h, input logic [5:0] s, input kind_t k);
        chs_t r;
        r.mapped = m;
        r.cyl    = c;
        r.head   = h;
        r.sit    = s;
        r.kind   = k;
        return r;
    endfunction

    function automatic void plan_word(input logic [1:0] op, input logic [5:0] idx,
                                      input logic [31:0] val, input logic [31:0] lsec);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.sel    = REG_SPT;
        r.data   = '0;
        r.op     = op;
        r.idx    = idx;
        r.val    = val;
        r.lsec   = lsec;
        r.typed  = 1'b0;
        r.want   = '0;
        plan.push_back(r);
    endfunction

    // Translate row whose answer can be read off directly
    function automatic void plan_typed(input logic [31:0] lsec, input chs_t want);
        plan_word(OP_TRANSLATE, 6'h15, 32'h5A5A_A5A5, lsec);
        plan[$].typed = 1'b1;
        plan[$].want  = want;
    endfunction

    function automatic void plan_reg(input cfg_reg_t sel, input logic [31:0] data);
        plan_word(OP_TRANSLATE, '0, '0, '0);
        plan[$].is_cfg = 1'b1;
        plan[$].sel    = sel;
        plan[$].data   = data;
    endfunction

    // Table contents: often small track numbers so that targeted sectors fit,
    // some wide values, and copies of existing entries to get duplicates
    function automatic logic [31:0] bad_value();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom_range(0, 4095);
            2:       return $urandom_range(0, 1 << 22);
            3:       return $urandom();
            4:       return trk_tab[$urandom_range(0, TRACK_TABLE_DEPTH - 1)];
            default: return sec_tab[$urandom_range(0, SECTOR_TABLE_DEPTH - 1)];
        endcase
    endfunction

    // Set unused upper bits now and then; the block must ignore them
    function automatic logic [31:0] junk_hi(input logic [31:0] v, input int w);
        logic [31:0] keep;
        keep = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
        return ($urandom_range(0, 3) == 0) ? ((v & keep) | ($urandom() & ~keep)) : v;
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'hFFFF_FF00;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd64;
            3:       return $urandom_range(65, 127);
            default: return $urandom_range(2, 63);
        endcase
    endfunction

    // Drop the input valid, let every owed result arrive, then let the block
    // finish any load or ignored word still in work before touching registers
    task automatic settle_block();
        item_if.valid <= 1'b0;
        while (chs_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        words_since_idle = 1'b0;
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [31:0] data);
        if (words_since_idle)
            settle_block();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= sel;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        // hold valid high; the next word lowers it
        cfg_open = 1'b1;
        case (sel)
            REG_SPT:          spt_reg   = data[5:0];
            REG_HEADS:        heads_reg = data[8:0];
            REG_ENABLE:       remap_on  = data[0];
            REG_TRACK_BASE:   trk_base  = data;
            REG_SECTOR_BASE:  sec_base  = data;
            REG_TRACK_COUNT:  trk_used  = data[6:0];
            REG_SECTOR_COUNT: sec_used  = data[6:0];
            default: ;
        endcase
    endtask

    // Offer one input word, in bursts with random gaps, and book its result
    task automatic offer_word(input logic [1:0] op, input logic [5:0] idx,
                              input logic [31:0] val, input logic [31:0] lsec,
                              input logic typed, input chs_t want);
        int gap;
        if (cfg_open)
        begin
            cfg_if.valid <= 1'b0;
            cfg_open = 1'b0;
        end
        if (burst_left == 0)
        begin
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 8);
            if (gap != 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_if.valid          <= 1'b1;
        item_if.op             <= op;
        item_if.entry_index    <= idx;
        item_if.entry_value    <= val;
        item_if.logical_sector <= lsec;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        words_since_idle = 1'b1;
        case (op)
            OP_LOAD_TRACK:  if (idx < TRACK_TABLE_DEPTH) trk_tab[idx] = val;
            OP_LOAD_SECTOR: if (idx < SECTOR_TABLE_DEPTH) sec_tab[idx] = val;
            OP_TRANSLATE:   chs_pending.push_back(typed ? want : chs_translate(lsec));
            default: ;
        endcase
    endtask

    // One full register setup per random phase; the first phases hit the extremes
    task automatic setup_phase(input int ph);
        logic [31:0] spt;
        logic [31:0] heads;
        logic [31:0] tc;
        logic [31:0] sc;
        case (ph)
            0:
            begin
                spt = 32'd63; heads = 32'd256; tc = 32'd64; sc = 32'd64;
            end
            1:
            begin
                spt = 32'd1; heads = 32'd1; tc = 32'd127; sc = 32'd65;
            end
            default:
            begin
                spt = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 63);
                case ($urandom_range(0, 5))
                    0:       heads = 32'd0;
                    1:       heads = $urandom_range(257, 511);
                    2:       heads = 32'd256;
                    default: heads = $urandom_range(1, 255);
                endcase
                tc = pick_count();
                sc = pick_count();
            end
        endcase
        write_reg(REG_SPT, junk_hi(spt, 6));
        write_reg(REG_HEADS, junk_hi(heads, 9));
        write_reg(REG_ENABLE, junk_hi((ph == 2) ? 32'd0 : 32'($urandom_range(0, 7) != 0), 1));
        write_reg(REG_TRACK_BASE, pick_base());
        write_reg(REG_SECTOR_BASE, pick_base());
        write_reg(REG_TRACK_COUNT, junk_hi(tc, 7));
        write_reg(REG_SECTOR_COUNT, junk_hi(sc, 7));
    endtask

    // Count each mismatch against the oldest booked result; print the first ten
    task automatic note_mismatch(input string what, input chs_t want, input chs_t got);
        chs_mismatches++;
        if (chs_mismatches <= 10)
        begin
            $write("MISMATCH %s: want %h cyl %h hd %0d sit %0d kind %0d, ",
                   what, want.mapped, want.cyl, want.head, want.sit, want.kind);
            $display("got %h cyl %h hd %0d sit %0d kind %0d",
                     got.mapped, got.cyl, got.head, got.sit, got.kind);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        chs_t got;
        chs_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.mapped = res_if.mapped_sector;
            got.cyl    = res_if.cylinder;
            got.head   = res_if.head;
            got.sit    = res_if.sector_in_track;
            got.kind   = kind_t'(res_if.remap_kind);
            if (chs_pending.size() == 0)
            begin
                note_mismatch("result with nothing owed", '0, got);
            end
            else
            begin
                want = chs_pending.pop_front();
                if (got.mapped !== want.mapped || got.cyl !== want.cyl ||
                    got.head !== want.head || got.sit !== want.sit ||
                    got.kind !== want.kind)
                    note_mismatch("wrong field", want, got);
            end
        end
    end

    // Receiver: switch between stall patterns, and hold off once for a long
    // stretch so the block fills up and back-pressures its input
    initial
    begin : result_side
        int   mode;
        int   mode_left;
        int   stall_left;
        int   hold_left;
        int   tick;
        logic squeezed;
        mode       = 0;
        mode_left  = 300;
        stall_left = 0;
        hold_left  = 0;
        tick       = 0;
        squeezed   = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (squeeze_go && !squeezed)
            begin
                squeezed  = 1'b1;
                hold_left = SQUEEZE_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(100, 800);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= ($urandom_range(0, 2) != 0);
                    2: res_if.ready <= ((tick % 9) < 5);
                    default:
                    begin
                        if (stall_left > 0)
                            stall_left--;
                        else if ($urandom_range(0, 15) == 0)
                            stall_left = $urandom_range(1, 60);
                        res_if.ready <= (stall_left == 0);
                    end
                endcase
            end
        end
    end

    // Watchdog: end the run if the block hangs
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int          ph;
        int          made;
        int          span;
        int          k;
        int          j;
        int          pick;
        logic [31:0] spt_now;
        logic [31:0] lsec;
        logic [1:0]  op;

        item_if.valid          <= 1'b0;
        item_if.op             <= OP_TRANSLATE;
        item_if.entry_index    <= '0;
        item_if.entry_value    <= '0;
        item_if.logical_sector <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.index           <= REG_SPT;
        cfg_if.data            <= '0;

        // Shadow state after reset; tables start zeroed only so copies stay known
        spt_reg   = SPT_RESET;
        heads_reg = HEADS_RESET;
        remap_on  = 1'b0;
        trk_base  = '0;
        sec_base  = '0;
        trk_used  = '0;
        sec_used  = '0;
        foreach (trk_tab[i]) trk_tab[i] = '0;
        foreach (sec_tab[i]) sec_tab[i] = '0;

        // Directed table. Defaults: 63 sectors/track, 16 heads, remap off.
        plan_typed(32'h0, chs(32'h0, 32'h0, 8'd0, 6'd0, KIND_NONE));
        plan_typed(32'hFFFF_FFFF, chs(32'hFFFF_FFFF, 32'd4260880, 8'd4, 6'd3, KIND_NONE));
        plan_typed(32'd1007, chs(32'd1007, 32'd0, 8'd15, 6'd62, KIND_NONE));
        plan_word(OP_UNUSED, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // swallowed
        plan_word(OP_LOAD_TRACK, 6'd0, 32'd2, 32'h0);
        plan_word(OP_LOAD_TRACK, 6'd1, 32'd2, 32'h0);                // duplicate track
        plan_word(OP_LOAD_TRACK, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        plan_word(OP_LOAD_SECTOR, 6'd0, 32'd5000, 32'h0);
        plan_word(OP_LOAD_SECTOR, 6'd1, 32'hFFFF_FFFF, 32'h0);
        plan_word(OP_LOAD_SECTOR, 6'h3F, 32'h0, 32'hFFFF_FFFF);
        plan_reg(REG_ENABLE, 32'd1);
        plan_reg(REG_TRACK_BASE, 32'h1000_0000);
        plan_reg(REG_SECTOR_BASE, 32'hFFFF_FFFF);
        plan_reg(REG_TRACK_COUNT, 32'd2);
        plan_reg(REG_SECTOR_COUNT, 32'd2);
        plan_word(OP_TRANSLATE, 6'h2A, 32'h1234_5678, 32'd130);       // bad track hit
        plan_word(OP_TRANSLATE, 6'h00, 32'h0, 32'd5000);              // bad sector hit
        // sector alternate base plus one wraps to zero
        plan_typed(32'hFFFF_FFFF, chs(32'h0, 32'h0, 8'd0, 6'd0, KIND_SECTOR));
        plan_word(OP_TRANSLATE, 6'h3F, 32'hFFFF_FFFF, 32'd125);       // neighbor track, no hit
        plan_reg(REG_SPT, 32'd0);                                      // taken as one
        plan_reg(REG_HEADS, 32'd0);                                    // taken as one
        plan_word(OP_TRANSLATE, 6'h01, 32'h0, 32'd2);
        plan_word(OP_TRANSLATE, 6'h01, 32'h0, 32'd5000);
        plan_reg(REG_SPT, 32'd63);
        plan_reg(REG_HEADS, 32'd511);                                  // clamped to 256
        plan_reg(REG_TRACK_BASE, 32'hFFFF_FFF0);
        plan_word(OP_TRANSLATE, 6'h00, 32'h0, 32'd150);               // track hit that wraps
        plan_word(OP_TRANSLATE, 6'h00, 32'h0, 32'hFFFF_FFFF);
        plan_reg(REG_HEADS, 32'd256);
        plan_reg(REG_SPT, 32'd1);
        plan_reg(REG_ENABLE, 32'd0);
        plan_word(OP_TRANSLATE, 6'h00, 32'h0, 32'd2);                 // remap off: passes through
        plan_typed(32'hFFFF_FFFF, chs(32'hFFFF_FFFF, 32'h00FF_FFFF, 8'd255, 6'd0, KIND_NONE));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].is_cfg)
                write_reg(plan[r].sel, plan[r].data);
            else
                offer_word(plan[r].op, plan[r].idx, plan[r].val, plan[r].lsec,
                           plan[r].typed, plan[r].want);
        end

        // Load every slot of both tables so that any count reads written entries only
        for (j = 0; j < TRACK_TABLE_DEPTH; j++)
            offer_word(OP_LOAD_TRACK, 6'(j), bad_value(), $urandom(), 1'b0, '0);
        for (j = 0; j < SECTOR_TABLE_DEPTH; j++)
            offer_word(OP_LOAD_SECTOR, 6'(j), bad_value(), $urandom(), 1'b0, '0);

        // Random phases: new register setup each time, then a mix of words
        // aimed at table hits, plain translates, reloads and unused op codes
        made = 0;
        ph   = 0;
        while (made < RANDOM_WORDS)
        begin
            setup_phase(ph);
            if (ph == 1)
                squeeze_go = 1'b1;
            spt_now = (spt_reg == 6'd0) ? 32'd1 : {26'd0, spt_reg};
            span = $urandom_range(120, 180);
            for (k = 0; k < span; k++)
            begin
                pick = $urandom_range(0, 99);
                op   = OP_TRANSLATE;
                lsec = $urandom();
                if (pick < 30)
                begin
                    // a sector inside a bad track, mostly one that is in use
                    j = (trk_used != 0 && $urandom_range(0, 3) != 0) ?
                        $urandom_range(0, ((trk_used > 64) ? 64 : int'(trk_used)) - 1) :
                        $urandom_range(0, TRACK_TABLE_DEPTH - 1);
                    lsec = trk_tab[j] * spt_now + $urandom_range(0, spt_now - 1);
                end
                else if (pick < 55)
                begin
                    j = (sec_used != 0 && $urandom_range(0, 3) != 0) ?
                        $urandom_range(0, ((sec_used > 64) ? 64 : int'(sec_used)) - 1) :
                        $urandom_range(0, SECTOR_TABLE_DEPTH - 1);
                    lsec = sec_tab[j] + (($urandom_range(0, 5) == 0) ? 32'd1 : 32'd0);
                end
                else if (pick < 70)
                begin
                    case ($urandom_range(0, 3))
                        0:       lsec = 32'hFFFF_FFFF - $urandom_range(0, 3);
                        1:       lsec = $urandom_range(0, 3);
                        default: lsec = $urandom();
                    endcase
                end
                else if (pick < 95)
                begin
                    op = ($urandom_range(0, 1) == 0) ? OP_LOAD_TRACK : OP_LOAD_SECTOR;
                end
                else
                begin
                    op = OP_UNUSED;
                end
                offer_word(op, 6'($urandom_range(0, 63)),
                           (op == OP_TRANSLATE || op == OP_UNUSED) ? $urandom() : bad_value(),
                           lsec, 1'b0, '0);
                made++;
            end
            ph++;
        end

        // Drain: wait for every owed result, then give the block time to
        // show any stray result before the verdict
        item_if.valid <= 1'b0;
        while (chs_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (chs_mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/bbr_pkg.sv
design/bbr_if.sv
design/bbr_ram.sv
design/bbr_div.sv
design/bad_block_remap_chs_top.sv
tb/tb_top.sv
